// File: hdl/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Constants, types and calendar helpers for the seconds-to-calendar core.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int unsigned NUM_STG = 7;

    localparam logic [1:0] CFG_START_DAY   = 2'd0;
    localparam logic [1:0] CFG_START_MONTH = 2'd1;
    localparam logic [1:0] CFG_START_YEAR  = 2'd2;

    localparam logic [4:0] RST_DAY   = 5'd1;
    localparam logic [3:0] RST_MONTH = 4'd1;
    localparam logic [6:0] RST_YEAR  = 7'd0;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;
    localparam logic [6:0] YEAR_LAST = 7'd99;

    // 86400 = 128 * 675; count >> 7 divided by 675 via reciprocal 2^35 / 675
    localparam logic [25:0] DAY_RECIP  = 26'd50903316;
    localparam int unsigned DAY_SHIFT  = 35;
    localparam logic [9:0]  DAY_ODD    = 10'd675;
    // hour: tod * 37283 >> 27, exact for tod < 86400
    localparam logic [15:0] HOUR_RECIP = 16'd37283;
    localparam logic [11:0] SECS_HOUR  = 12'd3600;
    // minute: within * 4370 >> 18, exact for within < 3600
    localparam logic [12:0] MIN_RECIP  = 13'd4370;
    localparam logic [5:0]  SECS_MIN   = 6'd60;
    localparam logic [16:0] SECS_DAY   = 17'd86400;

    typedef struct packed {
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } t_date;

    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            MONTH_FEB:                                 len = 5'd28;
            default:                                   len = 5'd30;
        endcase
        return len;
    endfunction

    function automatic t_date next_date(input t_date cur);
        t_date nxt;
        nxt = cur;
        if (cur.day < month_len(cur.month)) begin
            nxt.day = cur.day + 5'd1;
        end else begin
            nxt.day = 5'd1;
            if (cur.month == MONTH_DEC) begin
                nxt.month = MONTH_JAN;
                nxt.year  = (cur.year >= YEAR_LAST) ? 7'd0 : cur.year + 7'd1;
            end else if (cur.month > MONTH_DEC) begin
                nxt.month = MONTH_JAN;
            end else begin
                nxt.month = cur.month + 4'd1;
            end
        end
        return nxt;
    endfunction

endpackage

// File: hdl/seconds_count_to_clock_calendar_core.sv
// ----------------------------------------------------------------------------
// seconds_count_to_clock_calendar_core
// Stage registers, from sample to result, carry each accepted word to o_valid.
// Throughput: one word per cycle; each stage holds one word and empty stages
// close up while the output is stalled, so the input stalls only when full.
// Reset (synchronous, active low): clears all stage valid bits and loads the
// date 01/01/00; configuration writes preset the date directly.
// ----------------------------------------------------------------------------
// Splits a 32-bit seconds count into hours, minutes and seconds and advances
// a day/month/year calendar on midnight samples that meet no config write.
// ----------------------------------------------------------------------------
module seconds_count_to_clock_calendar_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_seconds_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_hours,
    output logic [5:0]  o_minutes,
    output logic [5:0]  o_seconds,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month_number,
    output logic [6:0]  o_year_two_digit,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [6:0]  i_cfg_data
);

    localparam int unsigned NS = scc_pkg::NUM_STG;

    logic [NS:1]   r_vld;
    logic [NS+1:1] rdy;

    // stage 1: sample
    logic [31:0] r1_count;
    // stage 2: reciprocal product for the day split
    logic [50:0] r2_prod;
    logic [24:0] r2_x;
    logic [6:0]  r2_low;
    // stage 3: time of day
    logic [16:0] r3_tod;
    // stage 4: hour
    logic [16:0] r4_tod;
    logic [4:0]  r4_h;
    scc_pkg::t_date r4_date;
    // stage 5: seconds within hour
    logic [11:0] r5_within;
    logic [4:0]  r5_h;
    scc_pkg::t_date r5_date;
    // stage 6: minute
    logic [11:0] r6_within;
    logic [5:0]  r6_m;
    logic [4:0]  r6_h;
    scc_pkg::t_date r6_date;
    // stage 7: result
    logic [4:0]  r7_h;
    logic [5:0]  r7_m;
    logic [5:0]  r7_s;
    scc_pkg::t_date r7_date;

    scc_pkg::t_date r_date;
    scc_pkg::t_date n_date;

    logic [50:0] n2_prod;
    logic [15:0] q_est;
    logic [24:0] rem_raw;
    logic [10:0] rem_low;
    logic [9:0]  rem_fix;
    logic [16:0] n3_tod;
    logic [32:0] hour_prod;
    logic [16:0] hour_secs;
    logic [16:0] within_full;
    logic [24:0] min_prod;
    logic [11:0] min_secs;
    logic [11:0] sec_full;
    logic        midnight;

    always_comb begin
        rdy[NS+1] = ~i_stall;
        for (int k = NS; k >= 1; k--) begin
            rdy[k] = ~r_vld[k] | rdy[k+1];
        end
    end

    assign o_stall = ~rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // day split: x = count / 128, remainder of x by 675
    assign n2_prod = 51'(r1_count[31:7]) * 51'(scc_pkg::DAY_RECIP);
    assign q_est   = r2_prod[scc_pkg::DAY_SHIFT +: 16];
    assign rem_raw = r2_x - 25'(q_est) * 25'(scc_pkg::DAY_ODD);
    assign rem_low = rem_raw[10:0];
    assign rem_fix = (rem_low >= 11'(scc_pkg::DAY_ODD))
                   ? 10'(rem_low - 11'(scc_pkg::DAY_ODD)) : rem_low[9:0];
    assign n3_tod  = {rem_fix, r2_low};

    assign hour_prod   = 33'(r3_tod) * 33'(scc_pkg::HOUR_RECIP);
    assign hour_secs   = 17'(r4_h) * 17'(scc_pkg::SECS_HOUR);
    assign within_full = r4_tod - hour_secs;
    assign min_prod    = 25'(r5_within) * 25'(scc_pkg::MIN_RECIP);
    assign min_secs    = 12'(r6_m) * 12'(scc_pkg::SECS_MIN);
    assign sec_full    = r6_within - min_secs;

    assign midnight = r_vld[3] && rdy[4] && (r3_tod == 17'd0);

    always_comb begin
        n_date = r_date;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                scc_pkg::CFG_START_DAY:   n_date.day   = i_cfg_data[4:0];
                scc_pkg::CFG_START_MONTH: n_date.month = i_cfg_data[3:0];
                scc_pkg::CFG_START_YEAR:  n_date.year  = i_cfg_data;
                default:                  n_date       = r_date;
            endcase
        end else if (midnight) begin
            n_date = scc_pkg::next_date(r_date);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_date.day   <= scc_pkg::RST_DAY;
            r_date.month <= scc_pkg::RST_MONTH;
            r_date.year  <= scc_pkg::RST_YEAR;
        end else begin
            r_date <= n_date;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r1_count <= i_seconds_count;
        end
        if (rdy[2]) begin
            r2_prod <= n2_prod;
            r2_x    <= r1_count[31:7];
            r2_low  <= r1_count[6:0];
        end
        if (rdy[3]) begin
            r3_tod <= n3_tod;
        end
        if (rdy[4]) begin
            r4_tod  <= r3_tod;
            r4_h    <= hour_prod[31:27];
            r4_date <= n_date;
        end
        if (rdy[5]) begin
            r5_within <= within_full[11:0];
            r5_h      <= r4_h;
            r5_date   <= r4_date;
        end
        if (rdy[6]) begin
            r6_within <= r5_within;
            r6_m      <= min_prod[23:18];
            r6_h      <= r5_h;
            r6_date   <= r5_date;
        end
        if (rdy[7]) begin
            r7_h    <= r6_h;
            r7_m    <= r6_m;
            r7_s    <= sec_full[5:0];
            r7_date <= r6_date;
        end
    end

    assign o_valid          = r_vld[NS];
    assign o_hours          = r7_h;
    assign o_minutes        = r7_m;
    assign o_seconds        = r7_s;
    assign o_day_of_month   = r7_date.day;
    assign o_month_number   = r7_date.month;
    assign o_year_two_digit = r7_date.year;

    a_tod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (r3_tod < scc_pkg::SECS_DAY))
        else $error("time of day out of range");

    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> (r4_h <= 5'd23))
        else $error("hour out of range");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_minutes < scc_pkg::SECS_MIN && o_seconds < scc_pkg::SECS_MIN))
        else $error("minute or second out of range");

    a_midnight_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (midnight && !i_cfg_we) |=> (r_date != $past(r_date)))
        else $error("midnight sample left the date unchanged");

    a_date_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!midnight && !i_cfg_we) |=> $stable(r_date))
        else $error("date changed without midnight or write");

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for seconds_count_to_clock_calendar_core.
// A table of directed words and date presets runs first: time-of-day
// extremes, repeated midnights, month and year rollovers, and out-of-range
// day, month and year presets. Random phases follow, each with a fresh
// date preset and a mix of midnight, near-midnight and free counter words.
// Every clock word is compared field by field against a table reading or an
// in-bench calendar, with random input idling and output stall save in one phase.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] CFG_DAY    = scc_pkg::CFG_START_DAY;
    localparam logic [1:0] CFG_MONTH  = scc_pkg::CFG_START_MONTH;
    localparam logic [1:0] CFG_YEAR   = scc_pkg::CFG_START_YEAR;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned RAND_PHASES = 6;
    localparam int unsigned PHASE_WORDS = 75;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } t_clock_word;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  idx;
        logic [6:0]  data;
        logic [31:0] count;
        logic        typed;
        t_clock_word fixed;
    } t_step;

    localparam int unsigned PLAN_ROWS = 40;
    localparam t_step PLAN [0:PLAN_ROWS-1] = '{
        '{ROW_WORD, CFG_DAY, 7'd0, 32'd86399, 1'b1, '{5'd23, 6'd59, 6'd59, 5'd1, 4'd1, 7'd0}},
        '{ROW_WORD, CFG_DAY, 7'd0, 32'd0, 1'b1, '{5'd0, 6'd0, 6'd0, 5'd2, 4'd1, 7'd0}},
        '{ROW_WORD, CFG_DAY, 7'd0, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_WORD, CFG_DAY, 7'd0, 32'd86400, 1'b1, '{5'd0, 6'd0, 6'd0, 5'd3, 4'd1, 7'd0}},
        '{ROW_WORD, CFG_DAY, 7'd0, 32'd86400, 1'b1, '{5'd0, 6'd0, 6'd0, 5'd4, 4'd1, 7'd0}},
        '{ROW_WORD, CFG_DAY, 7'd0, 32'd3599, 1'b1, '{5'd0, 6'd59, 6'd59, 5'd4, 4'd1, 7'd0}},
        '{ROW_WORD, CFG_DAY, 7'd0, 32'd3600, 1'b1, '{5'd1, 6'd0, 6'd0, 5'd4, 4'd1, 7'd0}},
        '{ROW_CFG, CFG_DAY, 7'd28, 32'd0, 1'b0, '0},
        '{ROW_CFG, CFG_MONTH, 7'd2, 32'd0, 1'b0, '0},
        '{ROW_CFG, CFG_YEAR, 7'd99, 32'd0, 1'b0, '0},
        '{ROW_WORD, CFG_DAY, 7'd0, 32'd172800, 1'b1, '{5'd0, 6'd0, 6'd0, 5'd1, 4'd3, 7'd99}},
        '{ROW_CFG, CFG_DAY, 7'd31, 32'd0, 1'b0, '0},
        '{ROW_CFG, CFG_MONTH, 7'd12, 32'd0, 1'b0, '0},
        '{ROW_WORD, CFG_DAY, 7'd0, 32'd0, 1'b1, '{5'd0, 6'd0, 6'd0, 5'd1, 4'd1, 7'd0}},
        '{ROW_CFG, CFG_DAY, 7'd0, 32'd0, 1'b0, '0},
        '{ROW_WORD, CFG_DAY, 7'd0, 32'd432000, 1'b1, '{5'd0, 6'd0, 6'd0, 5'd1, 4'd1, 7'd0}},
        '{ROW_CFG, CFG_MONTH, 7'd0, 32'd0, 1'b0, '0},
        '{ROW_CFG, CFG_DAY, 7'd30, 32'd0, 1'b0, '0},
        '{ROW_WORD, CFG_DAY, 7'd0, 32'd0, 1'b1, '{5'd0, 6'd0, 6'd0, 5'd1, 4'd1, 7'd0}},
        '{ROW_CFG, CFG_YEAR, 7'h7F, 32'd0, 1'b0, '0},
        '{ROW_CFG, CFG_DAY, 7'd30, 32'd0, 1'b0, '0},
        '{ROW_CFG, CFG_MONTH, 7'h7F, 32'd0, 1'b0, '0},
        '{ROW_WORD, CFG_DAY, 7'd0, 32'd0, 1'b1, '{5'd0, 6'd0, 6'd0, 5'd1, 4'd1, 7'd127}},
        '{ROW_CFG, CFG_MONTH, 7'd12, 32'd0, 1'b0, '0},
        '{ROW_CFG, CFG_DAY, 7'd31, 32'd0, 1'b0, '0},
        '{ROW_WORD, CFG_DAY, 7'd0, 32'd0, 1'b1, '{5'd0, 6'd0, 6'd0, 5'd1, 4'd1, 7'd0}},
        '{ROW_CFG, CFG_DAY, 7'd30, 32'd0, 1'b0, '0},
        '{ROW_CFG, CFG_MONTH, 7'd2, 32'd0, 1'b0, '0},
        '{ROW_WORD, CFG_DAY, 7'd0, 32'd0, 1'b1, '{5'd0, 6'd0, 6'd0, 5'd1, 4'd3, 7'd0}},
        '{ROW_CFG, CFG_UNUSED, 7'h55, 32'd0, 1'b0, '0},
        '{ROW_WORD, CFG_DAY, 7'd0, 32'd1, 1'b1, '{5'd0, 6'd0, 6'd1, 5'd1, 4'd3, 7'd0}},
        '{ROW_CFG, CFG_DAY, 7'h7F, 32'd0, 1'b0, '0},
        '{ROW_CFG, CFG_MONTH, 7'd4, 32'd0, 1'b0, '0},
        '{ROW_WORD, CFG_DAY, 7'd0, 32'd86400, 1'b1, '{5'd0, 6'd0, 6'd0, 5'd1, 4'd5, 7'd0}},
        '{ROW_WORD, CFG_DAY, 7'd0, 32'd12345678, 1'b0, '0},
        '{ROW_CFG, CFG_YEAR, 7'd98, 32'd0, 1'b0, '0},
        '{ROW_CFG, CFG_MONTH, 7'd12, 32'd0, 1'b0, '0},
        '{ROW_CFG, CFG_DAY, 7'd31, 32'd0, 1'b0, '0},
        '{ROW_WORD, CFG_DAY, 7'd0, 32'd0, 1'b1, '{5'd0, 6'd0, 6'd0, 5'd1, 4'd1, 7'd99}},
        '{ROW_WORD, CFG_DAY, 7'd0, 32'h8000_0000, 1'b0, '0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_seconds_count = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [4:0]  o_hours;
    logic [5:0]  o_minutes;
    logic [5:0]  o_seconds;
    logic [4:0]  o_day_of_month;
    logic [3:0]  o_month_number;
    logic [6:0]  o_year_two_digit;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [6:0]  i_cfg_data = '0;

    scc_pkg::t_date calendar;
    t_clock_word due_readings [$];
    bit          quiet_stretch = 1'b0;
    int unsigned mismatches = 0;
    int unsigned words_sent = 0;
    int unsigned words_checked = 0;
    int unsigned midnights = 0;
    int unsigned date_loads = 0;

    seconds_count_to_clock_calendar_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_seconds_count  (i_seconds_count),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_hours          (o_hours),
        .o_minutes        (o_minutes),
        .o_seconds        (o_seconds),
        .o_day_of_month   (o_day_of_month),
        .o_month_number   (o_month_number),
        .o_year_two_digit (o_year_two_digit),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic bit take_break();
        return !quiet_stretch && ($urandom_range(99) < 33);
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] month);
        case (month)
            scc_pkg::MONTH_FEB:                           return 5'd28;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12:  return 5'd31;
            default:                                      return 5'd30;
        endcase
    endfunction

    // turn one counter sample into a clock reading; advance the date on midnight
    function automatic t_clock_word read_clock(input logic [31:0] count);
        logic [31:0] tod;
        logic [31:0] in_hour;
        t_clock_word r;
        tod     = count % 32'd86400;
        in_hour = count % 32'd3600;
        if (tod == 32'd0) begin
            midnights++;
            if (calendar.day < days_in(calendar.month)) begin
                calendar.day = calendar.day + 5'd1;
            end else begin
                calendar.day = 5'd1;
                if (calendar.month == scc_pkg::MONTH_DEC) begin
                    calendar.month = scc_pkg::MONTH_JAN;
                    calendar.year  = (calendar.year >= scc_pkg::YEAR_LAST)
                                   ? 7'd0 : calendar.year + 7'd1;
                end else if (calendar.month > scc_pkg::MONTH_DEC) begin
                    calendar.month = scc_pkg::MONTH_JAN;
                end else begin
                    calendar.month = calendar.month + 4'd1;
                end
            end
        end
        r.hours   = 5'(tod / 32'd3600);
        r.minutes = 6'(in_hour / 32'd60);
        r.seconds = 6'(in_hour % 32'd60);
        r.day     = calendar.day;
        r.month   = calendar.month;
        r.year    = calendar.year;
        return r;
    endfunction

    task automatic send_word(input logic [31:0] count, input bit typed,
                             input t_clock_word fixed);
        t_clock_word pred;
        @(negedge i_clk);
        while (take_break()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_seconds_count <= count;
        do @(posedge i_clk); while (o_stall);
        pred = read_clock(count);
        due_readings.push_back(typed ? fixed : pred);
        words_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (due_readings.size() != 0) @(posedge i_clk);
        repeat (scc_pkg::NUM_STG + 2) @(posedge i_clk);
    endtask

    // preset one date register (or the unused index) with the pipeline empty
    task automatic load_date_reg(input logic [1:0] idx, input logic [6:0] data);
        drain();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_DAY:   calendar.day   = data[4:0];
            CFG_MONTH: calendar.month = data[3:0];
            CFG_YEAR:  calendar.year  = data[6:0];
            default: ;
        endcase
        date_loads++;
    endtask

    function automatic logic [31:0] pick_count();
        int unsigned sel;
        logic [31:0] k;
        logic [31:0] d;
        sel = $urandom_range(99);
        k   = $urandom_range(1, 49710);
        d   = $urandom_range(1, 5);
        if (sel < 35) begin
            return 32'($urandom_range(0, 49710)) * 32'd86400;
        end else if (sel < 45) begin
            return $urandom_range(1) ? k * 32'd86400 + d : k * 32'd86400 - d;
        end
        return $urandom;
    endfunction

    always @(negedge i_clk) begin
        i_stall <= !quiet_stretch && ($urandom_range(99) < 33);
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_clock_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_readings.size() == 0) begin
                $error("clock word with none outstanding");
                mismatches++;
            end else begin
                want = due_readings.pop_front();
                check_field("hours", 32'(want.hours), 32'(o_hours));
                check_field("minutes", 32'(want.minutes), 32'(o_minutes));
                check_field("seconds", 32'(want.seconds), 32'(o_seconds));
                check_field("day_of_month", 32'(want.day), 32'(o_day_of_month));
                check_field("month_number", 32'(want.month), 32'(o_month_number));
                check_field("year_two_digit", 32'(want.year), 32'(o_year_two_digit));
                words_checked++;
            end
        end
    end

    initial begin
        calendar = '{day: scc_pkg::RST_DAY, month: scc_pkg::RST_MONTH,
                     year: scc_pkg::RST_YEAR};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++) begin
            if (PLAN[r].kind == ROW_CFG) begin
                load_date_reg(PLAN[r].idx, PLAN[r].data);
            end else begin
                send_word(PLAN[r].count, PLAN[r].typed, PLAN[r].fixed);
            end
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            quiet_stretch = (p == 2);
            load_date_reg(CFG_DAY, ($urandom_range(3) == 0) ?
                          7'($urandom_range(0, 127)) : 7'($urandom_range(26, 31)));
            load_date_reg(CFG_MONTH, ($urandom_range(3) == 0) ?
                          7'($urandom_range(0, 127)) : 7'($urandom_range(1, 12)));
            load_date_reg(CFG_YEAR, ($urandom_range(3) == 0) ?
                          7'($urandom_range(0, 127)) : 7'($urandom_range(90, 99)));
            if ($urandom_range(2) == 0) begin
                load_date_reg(CFG_UNUSED, 7'($urandom_range(0, 127)));
            end
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_word(pick_count(), 1'b0, '0);
            end
        end
        quiet_stretch = 1'b0;

        drain();
        $display("Sent %0d counter words, checked %0d clock words.", words_sent,
                 words_checked);
        $display("Date presets: %0d; midnight advances: %0d.", date_loads, midnights);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/scc_pkg.sv
hdl/seconds_count_to_clock_calendar_core.sv
test/tb.sv
